>>> src/srrw_pkg.sv
// Shared types, constants and microcode table for the selective-repeat receive window.
package srrw_pkg;

  localparam int WINDOW_SLOTS = 16;
  localparam int SLOT_W = $clog2(WINDOW_SLOTS);
  localparam int DR_W = $clog2(WINDOW_SLOTS);
  localparam int REM_W = $clog2(2 * WINDOW_SLOTS);
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / WINDOW_SLOTS);
  localparam logic [REM_W-1:0] SLOTS_REM = REM_W'(WINDOW_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_SLOTS - 1);
  localparam logic [DR_W-1:0] DRAIN_MAX = DR_W'(WINDOW_SLOTS - 1);

  typedef enum logic [1:0] {
    KIND_DELIVER = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_FINISH  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_REM,
    OP_FIX,
    OP_MARK,
    OP_DLV,
    OP_READ,
    OP_DRN,
    OP_ACK,
    OP_FIN
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_HOLD_IN,
    C_NO_MAGIC,
    C_NO_EOF,
    C_NOT_INORDER,
    C_DRAIN_STOP
  } cond_t;

  typedef logic [3:0] step_t;

  localparam step_t S_WAIT  = 4'd0;
  localparam step_t S_CHK   = 4'd1;
  localparam step_t S_REM   = 4'd2;
  localparam step_t S_FIX   = 4'd3;
  localparam step_t S_MARK  = 4'd4;
  localparam step_t S_DLV   = 4'd5;
  localparam step_t S_RD    = 4'd6;
  localparam step_t S_TST   = 4'd7;
  localparam step_t S_DRN   = 4'd8;
  localparam step_t S_ACK   = 4'd9;
  localparam step_t S_NOMAG = 4'd10;
  localparam step_t S_FIN   = 4'd11;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ucode_t;

  typedef struct packed {
    logic              en;
    logic              good;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       tag;
  } win_wr_t;

  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    unique case (step)
      S_WAIT:  w = '{OP_LOAD, C_HOLD_IN,     S_CHK};
      S_CHK:   w = '{OP_MUL,  C_NO_MAGIC,    S_NOMAG};
      S_REM:   w = '{OP_REM,  C_NEXT,        S_WAIT};
      S_FIX:   w = '{OP_FIX,  C_NEXT,        S_WAIT};
      S_MARK:  w = '{OP_MARK, C_NOT_INORDER, S_ACK};
      S_DLV:   w = '{OP_DLV,  C_NEXT,        S_WAIT};
      S_RD:    w = '{OP_READ, C_NEXT,        S_WAIT};
      S_TST:   w = '{OP_NONE, C_DRAIN_STOP,  S_ACK};
      S_DRN:   w = '{OP_DRN,  C_ALWAYS,      S_RD};
      S_ACK:   w = '{OP_ACK,  C_ALWAYS,      S_WAIT};
      S_NOMAG: w = '{OP_NONE, C_NO_EOF,      S_WAIT};
      S_FIN:   w = '{OP_FIN,  C_ALWAYS,      S_WAIT};
      default: w = '{OP_NONE, C_ALWAYS,      S_WAIT};
    endcase
    return w;
  endfunction

endpackage

>>> src/srrw_window.sv
// Window store: per-slot valid bits and sequence tag memory with registered read.
module srrw_window import srrw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  win_wr_t           wr,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] rd_slot,
  output logic              rd_valid,
  output logic [31:0]       rd_tag
);

  logic [WINDOW_SLOTS-1:0] valid_bits;
  logic [31:0]             tags [WINDOW_SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (wr.en) begin
      valid_bits[wr.slot] <= wr.good;
    end
  end

  // tag written only for good packets; stale tags are masked by valid
  always_ff @(posedge clk) begin
    if (wr.en && wr.good) begin
      tags[wr.slot] <= wr.tag;
    end
    if (rd_en) begin
      rd_tag   <= tags[rd_slot];
      rd_valid <= valid_bits[rd_slot];
    end
  end

endmodule

>>> src/selective_repeat_receive_window_top.sv
// Top level: microcoded selective-repeat receive window, header path.
// Flow: a matching header runs REM, FIX and MARK; an in-order packet then delivers, drains
// released stored slots and acks, and any other matching header only acks. A bad magic word
//   gives no result without end of file, and a finish item with it. A stalled output holds
//   the sequencer.
// Reset (rst, synchronous): clears sequencer, expected sequence, magic word, valid bits.
module selective_repeat_receive_window_top import srrw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  // header request
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] packet_seq,
  input  logic [31:0] packet_magic,
  input  logic        checksum_good,
  input  logic        end_of_file,
  // result request
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [31:0] seq_value,
  output logic [5:0]  slot_index,
  output logic        from_store,
  output logic        eof_flag,
  output logic        last_result
);

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  step_t             step;
  step_t             step_next;
  logic [31:0]       expected_magic;
  logic [31:0]       expected_seq;
  logic [SLOT_W-1:0] exp_slot;      // always expected_seq mod WINDOW_SLOTS
  logic [DR_W-1:0]   drained;

  // captured header
  logic [31:0]       seq_r;
  logic              good_r;
  logic              eof_r;
  logic              magic_ok;

  // slot index arithmetic
  logic [31:0]       quot;          // floor(seq * RECIP / 2^32), at most one short
  logic [REM_W-1:0]  rem;
  logic [2*REM_W-1:0] qw_full;
  logic [REM_W-1:0]  qw_lo;

  // output register
  kind_t             out_kind;
  logic [31:0]       out_seq;
  logic [SLOT_W-1:0] out_slot;
  logic              out_store;
  logic              out_eof;
  logic              out_last;

  // window store
  win_wr_t           win_wr;
  logic              rd_en;
  logic              rd_valid;
  logic [31:0]       rd_tag;

  // ---------------------------------------------------------------------------
  // Sequencer control
  // ---------------------------------------------------------------------------
  ucode_t uw;
  logic   emits;
  logic   out_free;
  logic   hold;
  logic   taken;
  logic   in_order;
  logic   drain_stop;

  assign uw       = ucode_rom(step);
  assign in_ready = (step == S_WAIT);
  assign out_free = !out_valid || out_ready;
  assign emits    = (uw.op == OP_DLV) || (uw.op == OP_DRN) ||
                    (uw.op == OP_ACK) || (uw.op == OP_FIN);

  assign in_order   = good_r && (seq_r == expected_seq);
  assign drain_stop = (drained == DRAIN_MAX) || !rd_valid || (rd_tag != expected_seq);

  always_comb begin
    hold  = 1'b0;
    taken = 1'b0;
    unique case (uw.cond)
      C_NEXT:        taken = 1'b0;
      C_ALWAYS:      taken = 1'b1;
      C_HOLD_IN:     hold  = !in_valid;
      C_NO_MAGIC:    taken = !magic_ok;
      C_NO_EOF:      taken = !eof_r;
      C_NOT_INORDER: taken = !in_order;
      C_DRAIN_STOP:  taken = drain_stop;
      default:       taken = 1'b1;
    endcase
    if (emits && !out_free) begin
      hold = 1'b1;
    end
    priority if (hold) begin
      step_next = step;
    end else if (taken) begin
      step_next = uw.target;
    end else begin
      step_next = step + 4'd1;
    end
  end

  logic fire;
  assign fire = !hold;

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  // low bits of quot * WINDOW_SLOTS suffice: the true remainder is below 2*WINDOW_SLOTS
  assign qw_full = quot[REM_W-1:0] * SLOTS_REM;
  assign qw_lo   = qw_full[REM_W-1:0];

  assign win_wr.en   = fire && (uw.op == OP_MARK);
  assign win_wr.good = good_r;
  assign win_wr.slot = rem[SLOT_W-1:0];
  assign win_wr.tag  = seq_r;

  assign rd_en = fire && (uw.op == OP_READ);

  srrw_window u_window (
    .clk      (clk),
    .rst      (rst),
    .wr       (win_wr),
    .rd_en    (rd_en),
    .rd_slot  (exp_slot),
    .rd_valid (rd_valid),
    .rd_tag   (rd_tag)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step           <= S_WAIT;
      expected_magic <= '0;
      expected_seq   <= '0;
      exp_slot       <= '0;
      out_valid      <= 1'b0;
    end else begin
      step <= step_next;
      if (cfg_we) begin
        expected_magic <= cfg_wdata;
      end
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (fire && emits) begin
        out_valid <= 1'b1;
      end
      if (fire && uw.op == OP_DLV) begin
        // arriving packet is the expected one, so its slot is expected_seq mod slots
        expected_seq <= expected_seq + 32'd1;
        exp_slot     <= (rem[SLOT_W-1:0] == LAST_SLOT) ? '0 : rem[SLOT_W-1:0] + 1'b1;
      end
      if (fire && uw.op == OP_DRN) begin
        expected_seq <= expected_seq + 32'd1;
        exp_slot     <= (exp_slot == LAST_SLOT) ? '0 : exp_slot + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (fire) begin
      unique case (uw.op)
        OP_LOAD: begin
          seq_r    <= packet_seq;
          good_r   <= checksum_good;
          eof_r    <= end_of_file;
          magic_ok <= (packet_magic == expected_magic);
        end
        OP_MUL: begin
          quot <= 32'(({32'd0, seq_r} * {32'd0, RECIP}) >> 32);
        end
        OP_REM: begin
          rem <= seq_r[REM_W-1:0] - qw_lo;
        end
        OP_FIX: begin
          if (rem >= SLOTS_REM) begin
            rem <= rem - SLOTS_REM;
          end
        end
        OP_DLV: begin
          drained   <= '0;
          out_kind  <= KIND_DELIVER;
          out_seq   <= seq_r;
          out_slot  <= rem[SLOT_W-1:0];
          out_store <= 1'b0;
          out_eof   <= 1'b0;
          out_last  <= 1'b0;
        end
        OP_DRN: begin
          drained   <= drained + 1'b1;
          out_kind  <= KIND_DELIVER;
          out_seq   <= expected_seq;
          out_slot  <= exp_slot;
          out_store <= 1'b1;
          out_eof   <= 1'b0;
          out_last  <= 1'b0;
        end
        OP_ACK: begin
          out_kind  <= KIND_ACK;
          out_seq   <= expected_seq - 32'd1;
          out_slot  <= '0;
          out_store <= 1'b0;
          out_eof   <= eof_r;
          out_last  <= 1'b1;
        end
        OP_FIN: begin
          out_kind  <= KIND_FINISH;
          out_seq   <= '0;
          out_slot  <= '0;
          out_store <= 1'b0;
          out_eof   <= 1'b1;
          out_last  <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign kind        = out_kind;
  assign seq_value   = out_seq;
  assign slot_index  = 6'(out_slot);
  assign from_store  = out_store;
  assign eof_flag    = out_eof;
  assign last_result = out_last;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // remainder fully reduced before it addresses the window
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (step == S_MARK) |-> (rem < SLOTS_REM))
    else $error("slot index not reduced below window size");

  // a pending deliver or ack always trails expected_seq by one
  a_seq_track: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind == KIND_DELIVER || out_kind == KIND_ACK))
      |-> (out_seq + 32'd1 == expected_seq))
    else $error("result sequence out of step with expected sequence");

  // delivers never close out a request
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_last) |-> (out_kind != KIND_DELIVER))
    else $error("deliver item flagged as last result");

  // drain walk releases a slot only after a hit on the registered tag read
  a_drain_hit: assert property (@(posedge clk) disable iff (rst)
    (step == S_DRN) |-> (rd_valid && rd_tag == expected_seq && drained != DRAIN_MAX))
    else $error("drain released a slot that does not hold the expected sequence");

endmodule
